// ----- sv/pwl_pkg.sv -----
// shared types and constants for the piecewise linear table interpolator
// no dependencies
package pwl_pkg;
   localparam int TableDepth = 64;
   localparam int IdxBits = $clog2(TableDepth);
   localparam int CntBits = $clog2(TableDepth + 1);
   localparam int EnergyBits = 32;
   localparam int RateBits = 32;
   localparam int ProdBits = EnergyBits + RateBits;
   localparam int QDepth = 2;
   localparam int QIdxBits = $clog2(QDepth);
   localparam int QCntBits = $clog2(QDepth + 1);

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_CLAMP_LOW = 3'd1,
      ST_CLAMP_HIGH = 3'd2,
      ST_EMPTY = 3'd3,
      ST_FULL = 3'd4,
      ST_NO_SEGMENT = 3'd5
   } status_type;

   // one classified word handed from front to back
   typedef struct packed {
      cmd_type cmd;
      logic [EnergyBits-1:0] energy;
      logic [RateBits-1:0] rate;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_FIRST, BK_LAST, BK_SCAN, BK_MUL, BK_DIV, BK_DONE
   } back_state_type;
endpackage

// ----- sv/pwl_front.sv -----
// front: input queue that decouples acceptance from the table engine
// depends on pwl_pkg
module pwl_front (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_stall,
   input pwl_pkg::job_type in_job,
   output logic out_valid,
   input logic out_take,
   output pwl_pkg::job_type out_job
);
   import pwl_pkg::*;

   job_type q_ff [QDepth];
   logic [QIdxBits-1:0] wp_ff, rp_ff;
   logic [QCntBits-1:0] cnt_ff;
   logic push, pop;

   assign in_stall = (cnt_ff == QCntBits'(QDepth));
   assign push = in_valid && !in_stall;
   assign out_valid = (cnt_ff != '0);
   assign pop = out_valid && out_take;
   assign out_job = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_job;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + QCntBits'(push) - QCntBits'(pop);
      end
   end
endmodule

// ----- sv/pwl_back.sv -----
// back: table store, linear search, multiply and serial divide
// depends on pwl_pkg
module pwl_back (
   input logic clock,
   input logic reset,
   input logic job_valid,
   output logic job_take,
   input pwl_pkg::job_type job,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [31:0] rsp_rate_out,
   output logic [2:0] rsp_status
);
   import pwl_pkg::*;

   logic [EnergyBits-1:0] e_mem [TableDepth];
   logic [RateBits-1:0] r_mem [TableDepth];
   logic [EnergyBits-1:0] e_rd_ff;
   logic [RateBits-1:0] r_rd_ff;

   back_state_type state_ff, state_in;
   logic [CntBits-1:0] count_ff;
   logic [IdxBits-1:0] addr_ff, addr_in;
   logic [EnergyBits-1:0] x_ff, elo_ff, elo_in;
   logic [RateBits-1:0] rlo_ff, rlo_in;
   logic [EnergyBits-1:0] span_ff;
   logic [RateBits-1:0] mag_ff;
   logic neg_ff;
   logic [ProdBits-1:0] prod_ff;
   logic [EnergyBits-1:0] rem_ff;
   logic [6:0] bit_ff;
   logic out_v_ff;
   logic [31:0] out_r_ff;
   status_type out_s_ff;
   logic [RateBits-1:0] res_r;
   status_type res_s;
   logic finish;
   logic [EnergyBits:0] trial;

   assign rsp_valid = out_v_ff;
   assign rsp_rate_out = out_r_ff;
   assign rsp_status = out_s_ff;
   assign trial = {rem_ff, prod_ff[ProdBits-1]};

   // table memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && job_take && job.cmd == CMD_APPEND
          && count_ff < CntBits'(TableDepth)) begin
         e_mem[count_ff[IdxBits-1:0]] <= job.energy;
         r_mem[count_ff[IdxBits-1:0]] <= job.rate;
      end
      e_rd_ff <= e_mem[addr_in];
      r_rd_ff <= r_mem[addr_in];
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      elo_in = elo_ff;
      rlo_in = rlo_ff;
      job_take = 1'b0;
      finish = 1'b0;
      res_r = '0;
      res_s = ST_OK;
      case (state_ff)
         BK_IDLE: begin
            addr_in = '0;
            if (job_valid && !out_v_ff) begin
               job_take = 1'b1;
               if (job.cmd == CMD_QUERY) begin
                  if (count_ff == '0) begin
                     finish = 1'b1;
                     res_s = ST_EMPTY;
                  end else state_in = BK_FIRST;
               end else begin
                  finish = 1'b1;
                  if (job.cmd == CMD_APPEND && count_ff >= CntBits'(TableDepth))
                     res_s = ST_FULL;
               end
            end
         end
         BK_FIRST: begin
            if (x_ff <= e_rd_ff) begin
               finish = 1'b1;
               res_r = r_rd_ff;
               res_s = ST_CLAMP_LOW;
               state_in = BK_IDLE;
            end else begin
               addr_in = IdxBits'(count_ff - 1'b1);
               state_in = BK_LAST;
            end
         end
         BK_LAST: begin
            if (x_ff >= e_rd_ff) begin
               finish = 1'b1;
               res_r = r_rd_ff;
               res_s = ST_CLAMP_HIGH;
               state_in = BK_IDLE;
            end else begin
               addr_in = '0;
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            // e_rd/r_rd hold entry addr_ff
            if (addr_ff != '0 && x_ff <= e_rd_ff) begin
               if (e_rd_ff <= elo_ff || x_ff <= elo_ff) begin
                  finish = 1'b1;
                  res_s = ST_NO_SEGMENT;
                  state_in = BK_IDLE;
               end else state_in = BK_MUL;
            end else if (CntBits'(addr_ff) + 1'b1 >= count_ff) begin
               finish = 1'b1;
               res_s = ST_NO_SEGMENT;
               state_in = BK_IDLE;
            end else begin
               elo_in = e_rd_ff;
               rlo_in = r_rd_ff;
               addr_in = addr_ff + 1'b1;
            end
         end
         BK_MUL: state_in = BK_DIV;
         BK_DIV: if (bit_ff == 7'(ProdBits - 1)) state_in = BK_DONE;
         BK_DONE: begin
            finish = 1'b1;
            res_s = ST_OK;
            res_r = neg_ff ? rlo_ff - RateBits'(prod_ff) : rlo_ff + RateBits'(prod_ff);
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      elo_ff <= elo_in;
      rlo_ff <= rlo_in;
      if (state_ff == BK_IDLE && job_take) x_ff <= job.energy;
      if (state_ff == BK_SCAN && state_in == BK_MUL) begin
         span_ff <= e_rd_ff - elo_ff;
         neg_ff <= r_rd_ff < rlo_ff;
         mag_ff <= (r_rd_ff >= rlo_ff) ? r_rd_ff - rlo_ff : rlo_ff - r_rd_ff;
      end
      if (state_ff == BK_MUL) begin
         prod_ff <= ProdBits'(mag_ff) * ProdBits'(x_ff - elo_ff);
         rem_ff <= '0;
         bit_ff <= '0;
      end
      // restoring division, one quotient bit per cycle, quotient shifts into prod
      if (state_ff == BK_DIV) begin
         bit_ff <= bit_ff + 1'b1;
         if (trial >= {1'b0, span_ff}) begin
            rem_ff <= EnergyBits'(trial - {1'b0, span_ff});
            prod_ff <= {prod_ff[ProdBits-2:0], 1'b1};
         end else begin
            rem_ff <= trial[EnergyBits-1:0];
            prod_ff <= {prod_ff[ProdBits-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out_r_ff <= 32'(res_r);
         out_s_ff <= res_s;
      end
      if (reset) begin
         out_v_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (finish) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         if (state_ff == BK_IDLE && job_take) begin
            if (job.cmd == CMD_CLEAR) count_ff <= '0;
            else if (job.cmd == CMD_APPEND && count_ff < CntBits'(TableDepth))
               count_ff <= count_ff + 1'b1;
         end
      end
   end
endmodule

// ----- sv/piecewise_linear_table_interp_top.sv -----
// top level of the piecewise linear breakpoint table interpolator
// depends on pwl_pkg, pwl_front, pwl_back
//
// commands: clear, append (energy, rate) pair, query. one result word per
// command word. a query checks the two end clamps, then scans the
// breakpoints one at a time (up to 64), then does one multiply and the
// bit-serial restoring divide. the single-port table read in the scan loop
// and the one-bit-per-cycle divider set the query time. a two-word queue in
// front lets the sender keep going while a query is busy, and the result
// register holds a word while the receiver stalls. table entries are not
// cleared at reset; only the fill count is.
module piecewise_linear_table_interp_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_command,
   input logic [31:0] req_energy,
   input logic [31:0] req_rate_in,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [31:0] rsp_rate_out,
   output logic [2:0] rsp_status
);
   import pwl_pkg::*;

   job_type in_job, q_job;
   logic q_valid, q_take;

   // command word packed for the queue
   assign in_job = '{cmd: cmd_type'(req_command), energy: req_energy, rate: req_rate_in};

   pwl_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_job(in_job),
      .out_valid(q_valid), .out_take(q_take), .out_job(q_job)
   );

   pwl_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_take(q_take), .job(q_job),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_rate_out(rsp_rate_out), .rsp_status(rsp_status)
   );

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rate_out) && $stable(rsp_status))
      else $error("result changed under stall");
   // error statuses carry zero rate
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL
                    || rsp_status == ST_NO_SEGMENT) |-> rsp_rate_out == 32'd0)
      else $error("error status with nonzero rate");
   // status code range
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd5)
      else $error("bad status code");
endmodule

// ----- test/tb.sv -----
// testbench for the piecewise linear breakpoint table interpolator
// depends on pwl_pkg and piecewise_linear_table_interp_top
`timescale 1ns / 100ps

module tb;
   import pwl_pkg::*;

   typedef struct {
      logic [31:0] rate;
      logic [2:0] status;
   } rsp_word_type;

   // keeps the breakpoint table mirror and the words still owed
   class interp_board;
      logic [31:0] energy_tab[TableDepth];
      logic [31:0] rate_tab[TableDepth];
      int fill;
      rsp_word_type owed[$];
      int errors;

      function new();
         fill = 0;
         errors = 0;
      endfunction

      task report_bad(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function rsp_word_type lookup(logic [31:0] x);
         rsp_word_type w;
         logic [31:0] e_lo, e_hi, r_lo, r_hi;
         logic [63:0] prod, q;
         w.rate = 0;
         w.status = ST_NO_SEGMENT;
         if (fill == 0) begin
            w.status = ST_EMPTY;
            return w;
         end
         if (x <= energy_tab[0]) begin
            w.rate = rate_tab[0];
            w.status = ST_CLAMP_LOW;
            return w;
         end
         if (x >= energy_tab[fill-1]) begin
            w.rate = rate_tab[fill-1];
            w.status = ST_CLAMP_HIGH;
            return w;
         end
         for (int i = 1; i < fill; i++) begin
            if (x <= energy_tab[i]) begin
               e_lo = energy_tab[i-1];
               e_hi = energy_tab[i];
               r_lo = rate_tab[i-1];
               r_hi = rate_tab[i];
               if (e_hi <= e_lo || x <= e_lo) return w;
               if (r_hi >= r_lo) prod = 64'(r_hi - r_lo) * 64'(x - e_lo);
               else prod = 64'(r_lo - r_hi) * 64'(x - e_lo);
               q = prod / 64'(e_hi - e_lo);
               w.rate = (r_hi >= r_lo) ? r_lo + q[31:0] : r_lo - q[31:0];
               w.status = ST_OK;
               return w;
            end
         end
         return w;
      endfunction

      function void note_word(logic [1:0] cmd, logic [31:0] e, logic [31:0] r);
         rsp_word_type w;
         w.rate = 0;
         w.status = ST_OK;
         case (cmd)
            CMD_CLEAR: fill = 0;
            CMD_APPEND: begin
               if (fill < TableDepth) begin
                  energy_tab[fill] = e;
                  rate_tab[fill] = r;
                  fill++;
               end else w.status = ST_FULL;
            end
            CMD_QUERY: w = lookup(e);
            default: ;
         endcase
         owed = {owed, w};
      endfunction

      task check_word(logic [31:0] rate, logic [2:0] status);
         rsp_word_type w;
         if (owed.size() == 0) begin
            report_bad("result word with nothing owed");
            return;
         end
         w = owed.pop_front();
         if (status !== w.status)
            report_bad($sformatf("status %0d want %0d", status, w.status));
         if (rate !== w.rate)
            report_bad($sformatf("rate %h want %h", rate, w.rate));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_command = 0;
   logic [31:0] req_energy = 0;
   logic [31:0] req_rate_in = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [31:0] rsp_rate_out;
   logic [2:0] rsp_status;

   interp_board board = new();
   bit quiet = 0;   // no idling in the last stretch
   logic [31:0] ramp_e;
   logic [31:0] ramp_r;

   piecewise_linear_table_interp_top DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // receiver: random stall bursts, check every accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_rate_out, rsp_status);
   end

   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         n = $urandom_range(1, 14);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // send one word and wait for acceptance; valid stays high back to back
   task automatic send_word(logic [1:0] cmd, logic [31:0] e, logic [31:0] r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_energy <= e;
      req_rate_in <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(cmd, e, r);
   endtask

   // sorted table with random spacing, sizes mostly small
   task automatic load_ramp(int n, bit wide);
      logic [31:0] step;
      send_word(CMD_CLEAR, $urandom, $urandom);
      ramp_e = wide ? $urandom_range(0, 1000) : $urandom_range(0, 32'hffff);
      for (int i = 0; i < n; i++) begin
         ramp_r = $urandom;
         send_word(CMD_APPEND, ramp_e, ramp_r);
         step = wide ? $urandom_range(1, 32'h7fffffff / (n + 1))
                     : $urandom_range(1, 5000);
         ramp_e += step;
      end
   endtask

   function automatic logic [31:0] pick_energy();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 0;
      if (k == 1) return 32'hffffffff;
      if (board.fill > 0 && k < 4) return board.energy_tab[$urandom_range(0, board.fill-1)];
      if (board.fill > 1 && k < 8)
         return $urandom_range(board.energy_tab[0], board.energy_tab[board.fill-1]);
      return $urandom;
   endfunction

   initial begin
      int sent;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty, single entry, extremes, full table, unknown command
      send_word(CMD_QUERY, 32'h1234, 0);
      send_word(CMD_NONE, 32'hffffffff, 32'hffffffff);
      send_word(CMD_APPEND, 32'h100, 32'hffffffff);
      send_word(CMD_QUERY, 32'h100, 0);
      send_word(CMD_QUERY, 32'h200, 0);
      send_word(CMD_QUERY, 0, 0);
      send_word(CMD_APPEND, 32'hffffffff, 0);
      send_word(CMD_QUERY, 32'h80000000, 32'hffffffff);
      send_word(CMD_QUERY, 32'hfffffffe, 0);
      send_word(CMD_QUERY, 32'hffffffff, 0);
      send_word(CMD_CLEAR, 0, 0);
      send_word(CMD_APPEND, 0, 0);
      send_word(CMD_APPEND, 32'hffffffff, 32'hffffffff);
      send_word(CMD_QUERY, 32'h7fffffff, 0);
      // unsorted table: search still finds a nonzero span
      send_word(CMD_APPEND, 32'h10, 32'h55);
      send_word(CMD_APPEND, 32'h20, 32'haa);
      send_word(CMD_QUERY, 32'h15, 0);
      send_word(CMD_QUERY, 32'hfffffff0, 0);
      load_ramp(TableDepth, 1);
      send_word(CMD_APPEND, 32'hffffffff, 32'h5a5a5a5a);
      send_word(CMD_QUERY, pick_energy(), 0);
      sent = 0;
      while (sent < 1850) begin
         if (sent > 1650) quiet = 1;
         case ($urandom_range(0, 19))
            0: begin
               load_ramp($urandom_range(0, 9) == 0 ? TableDepth : $urandom_range(1, 8),
                          $urandom_range(0, 1));
               sent += board.fill + 1;
            end
            1: send_word(CMD_APPEND, $urandom, $urandom);
            2: send_word(CMD_NONE, $urandom, $urandom);
            3: send_word(CMD_CLEAR, $urandom, $urandom);
            default: send_word(CMD_QUERY, pick_energy(), $urandom);
         endcase
         sent++;
      end
      req_valid <= 0;
      quiet = 1;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/pwl_pkg.sv
sv/pwl_front.sv
sv/pwl_back.sv
sv/piecewise_linear_table_interp_top.sv
test/tb.sv
